// ----- hw/rtl/rpwu_pkg.sv -----
// shared types, codes and widths of the rprop weight update core
package rpwu_pkg;

	localparam int IDX_W   = 10;
	localparam int WORD_W  = 32;
	localparam int STEP_W  = 31;
	localparam int FACT_W  = 16;
	localparam int SIGN_W  = 2;
	localparam int OP_W    = 2;
	localparam int KIND_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_SHIFT = 15;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_GREW   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REVERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HELD   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PLAIN  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GROW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHRINK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 3'd4;

	// stored gradient sign codes, two's complement
	localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
	localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
	localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;
	localparam logic [SIGN_W-1:0] SIGN_BAD  = 2'b10;

	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

	typedef struct packed {
		logic [FACT_W-1:0] grow;
		logic [FACT_W-1:0] shrink;
		logic [STEP_W-1:0] ceiling;
		logic [STEP_W-1:0] floor_step;
		logic [STEP_W-1:0] initial_step;
	} cfg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] weight;
		logic [STEP_W-1:0]        step;
		logic [SIGN_W-1:0]        sign;
	} entry_t;

	typedef struct packed {
		logic                     start;
		entry_t                   entry;
		logic signed [WORD_W-1:0] grad;
	} alu_req_t;

	typedef struct packed {
		logic                     done;
		entry_t                   entry;
		logic [KIND_W-1:0]        kind;
	} alu_rsp_t;

endpackage

// ----- hw/rtl/rpwu_if.sv -----
// request and result channel interfaces of the rprop weight update core
interface rpwu_item_if import rpwu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic [IDX_W-1:0]         weight_index;
	logic signed [WORD_W-1:0] operand_value;

	modport source (output valid, opcode, weight_index, operand_value, input ready);
	modport sink   (input valid, opcode, weight_index, operand_value, output ready);
endinterface

interface rpwu_result_if import rpwu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         result_index;
	logic signed [WORD_W-1:0] weight_value;
	logic [STEP_W-1:0]        step_value;
	logic [KIND_W-1:0]        update_kind;

	modport source (output valid, result_index, weight_value, step_value, update_kind,
		input ready);
	modport sink   (input valid, result_index, weight_value, step_value, update_kind,
		output ready);
endinterface

// ----- hw/rtl/rpwu_cfg.sv -----
// configuration registers of the rprop weight update core
module rpwu_cfg import rpwu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grow         <= 16'd39322;
			cfg_q.shrink       <= 16'd16384;
			cfg_q.ceiling      <= 31'd838860800;
			cfg_q.floor_step   <= 31'd17;
			cfg_q.initial_step <= 31'd167772;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GROW:    cfg_q.grow         <= cfg_wdata[FACT_W-1:0];
				CFG_SHRINK:  cfg_q.shrink       <= cfg_wdata[FACT_W-1:0];
				CFG_CEILING: cfg_q.ceiling      <= cfg_wdata;
				CFG_FLOOR:   cfg_q.floor_step   <= cfg_wdata;
				CFG_INITIAL: cfg_q.initial_step <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/rpwu_store.sv -----
// weight, step and sign memory with one registered read port and one write port
module rpwu_store import rpwu_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/rpwu_alu.sv -----
// three-stage rprop update: step scaling, step clamp and move, weight add and saturate
module rpwu_alu import rpwu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam int PROD_W = STEP_W + FACT_W;
	localparam int SUM_W  = WORD_W + 2;

	// stage 1 signals
	logic                     v_s1;
	logic [PROD_W-1:0]        prod_s1;
	logic [KIND_W-1:0]        kind_s1;
	logic [SIGN_W-1:0]        gs_s1;
	logic [SIGN_W-1:0]        ps_s1;
	logic [STEP_W-1:0]        step_s1;
	logic signed [WORD_W-1:0] weight_s1;

	// stage 2 signals
	logic                     v_s2;
	logic [STEP_W-1:0]        step_s2;
	logic [STEP_W-1:0]        mag_s2;
	logic                     sub_s2;
	logic [SIGN_W-1:0]        sign_s2;
	logic [KIND_W-1:0]        kind_s2;
	logic signed [WORD_W-1:0] weight_s2;

	// stage 3 signals
	logic                     v_s3;
	entry_t                   entry_s3;
	logic [KIND_W-1:0]        kind_s3;

	logic              g_pos, g_neg, p_pos, p_neg, same, flip;
	logic [SIGN_W-1:0] gs;
	logic [FACT_W-1:0] factor;

	logic [WORD_W-1:0] scaled;
	logic [STEP_W-1:0] step_grow, step_sat, step_shrink;
	logic [STEP_W-1:0] step_nx, mag_nx;
	logic              sub_nx;
	logic [SIGN_W-1:0] sign_nx;

	logic signed [SUM_W-1:0] wx, mx, sum;
	logic signed [WORD_W-1:0] weight_nx;

	// sign comparison and factor choice
	always_comb begin
		g_pos  = !req.grad[WORD_W-1] && (|req.grad);
		g_neg  = req.grad[WORD_W-1];
		p_pos  = (req.entry.sign == SIGN_POS);
		p_neg  = (req.entry.sign == SIGN_NEG);
		same   = (g_pos && p_pos) || (g_neg && p_neg);
		flip   = (g_pos && p_neg) || (g_neg && p_pos);
		gs     = g_pos ? SIGN_POS : (g_neg ? SIGN_NEG : SIGN_ZERO);
		factor = same ? cfg.grow : cfg.shrink;
	end

	// stage 1: step times factor
	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_s1   <= PROD_W'(req.entry.step) * PROD_W'(factor);
			kind_s1   <= same ? KIND_GREW : (flip ? KIND_REVERT : KIND_HELD);
			gs_s1     <= gs;
			ps_s1     <= req.entry.sign;
			step_s1   <= req.entry.step;
			weight_s1 <= req.entry.weight;
		end
	end

	// clamp the scaled step and pick the weight move
	always_comb begin
		scaled      = prod_s1[PROD_W-1:FRAC_SHIFT];
		step_grow   = (scaled > WORD_W'(cfg.ceiling)) ? cfg.ceiling : scaled[STEP_W-1:0];
		step_sat    = scaled[WORD_W-1] ? STEP_MAX : scaled[STEP_W-1:0];
		step_shrink = (step_sat < cfg.floor_step) ? cfg.floor_step : step_sat;
		unique case (kind_s1)
			KIND_GREW: begin
				step_nx = step_grow;
				mag_nx  = step_grow;
				sub_nx  = (gs_s1 == SIGN_POS);
				sign_nx = gs_s1;
			end
			KIND_REVERT: begin
				// undo the previous signed move with the old step
				step_nx = step_shrink;
				mag_nx  = step_s1;
				sub_nx  = (ps_s1 == SIGN_NEG);
				sign_nx = SIGN_ZERO;
			end
			default: begin
				step_nx = step_s1;
				mag_nx  = (gs_s1 == SIGN_ZERO) ? '0 : step_s1;
				sub_nx  = (gs_s1 == SIGN_POS);
				sign_nx = gs_s1;
			end
		endcase
	end

	// stage 2: new step and move
	always_ff @(posedge clk) begin
		if (v_s1) begin
			step_s2   <= step_nx;
			mag_s2    <= mag_nx;
			sub_s2    <= sub_nx;
			sign_s2   <= sign_nx;
			kind_s2   <= kind_s1;
			weight_s2 <= weight_s1;
		end
	end

	// weight add with saturation
	always_comb begin
		wx  = SUM_W'(weight_s2);
		mx  = SUM_W'(mag_s2);
		sum = sub_s2 ? (wx - mx) : (wx + mx);
		if (sum[SUM_W-1:WORD_W-1] == '0 || sum[SUM_W-1:WORD_W-1] == '1) begin
			weight_nx = sum[WORD_W-1:0];
		end else if (sum[SUM_W-1]) begin
			weight_nx = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			weight_nx = {1'b0, {(WORD_W-1){1'b1}}};
		end
	end

	// stage 3: updated entry
	always_ff @(posedge clk) begin
		if (v_s2) begin
			entry_s3.weight <= weight_nx;
			entry_s3.step   <= step_s2;
			entry_s3.sign   <= sign_s2;
			kind_s3         <= kind_s2;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign rsp.done  = v_s3;
	assign rsp.entry = entry_s3;
	assign rsp.kind  = kind_s3;

endmodule

// ----- hw/rtl/rprop_weight_update_core.sv -----
// Rprop weight update core: per-entry weight, step and gradient sign held in one
// synchronous memory of WEIGHT_COUNT entries, read, modified and written back. One
// request is in work at a time. A load or read goes from acceptance through memory read
// and finish to the next acceptance; an update goes through memory read, then the
// three-stage multiply, clamp and saturating add pipeline, then write-back. Each
// request gives exactly one result; a result waiting in the output register does not
// stop the next request from being accepted, only its write-back waits for the slot.
// Indexes at or above WEIGHT_COUNT change nothing and return weight 0, step 0. The
// memory has no reset: reading an entry that was never loaded gives undefined fields.
module rprop_weight_update_core import rpwu_pkg::*; #(
	parameter int WEIGHT_COUNT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rpwu_item_if.sink            item,
	rpwu_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_wdata
);

	localparam int AW = $clog2(WEIGHT_COUNT);
	localparam int XW = (AW > IDX_W) ? AW : IDX_W;

	typedef enum logic [1:0] {S_IDLE, S_RD, S_CALC, S_FIN} state_t;

	state_t                   state_q;
	logic [OP_W-1:0]          op_q;
	logic [IDX_W-1:0]         idx_q;
	logic [AW-1:0]            addr_q;
	logic                     in_range_q;
	logic signed [WORD_W-1:0] operand_q;
	entry_t                   entry_q;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic signed [WORD_W-1:0] out_weight_q;
	logic [STEP_W-1:0]        out_step_q;
	logic [KIND_W-1:0]        out_kind_q;

	cfg_t     cfg;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	entry_t   rd_data;
	entry_t   wr_data;
	logic     mem_we;
	logic     accept;
	logic     out_free;
	logic     is_update;
	logic [XW-1:0] idx_x;
	logic signed [WORD_W-1:0] fin_weight;
	logic [STEP_W-1:0]        fin_step;
	logic [KIND_W-1:0]        fin_kind;
	logic                     fin_write;

	rpwu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// request handshake and memory address
	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign idx_x      = XW'(item.weight_index);
	assign is_update  = (op_q == OP_UPDATE) && in_range_q;

	rpwu_store #(
		.DEPTH (WEIGHT_COUNT),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (idx_x[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (mem_we),
		.wr_addr (addr_q),
		.wr_data (wr_data)
	);

	// update pipeline starts as the entry comes out of memory
	assign alu_req.start = (state_q == S_RD) && is_update;
	assign alu_req.entry = rd_data;
	assign alu_req.grad  = operand_q;

	rpwu_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// finishing values by operation
	always_comb begin
		fin_weight = entry_q.weight;
		fin_step   = entry_q.step;
		fin_kind   = KIND_PLAIN;
		fin_write  = 1'b0;
		wr_data    = alu_rsp.entry;
		if (!in_range_q) begin
			fin_weight = '0;
			fin_step   = '0;
		end else if (op_q == OP_LOAD) begin
			fin_weight     = operand_q;
			fin_step       = cfg.initial_step;
			fin_write      = 1'b1;
			wr_data.weight = operand_q;
			wr_data.step   = cfg.initial_step;
			wr_data.sign   = SIGN_ZERO;
		end else if (op_q == OP_UPDATE) begin
			fin_weight = alu_rsp.entry.weight;
			fin_step   = alu_rsp.entry.step;
			fin_kind   = alu_rsp.kind;
			fin_write  = 1'b1;
		end
	end

	assign out_free = !out_valid_q || result.ready;
	assign mem_we   = (state_q == S_FIN) && out_free && fin_write;

	// sequencer with item and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= item.opcode;
						idx_q      <= item.weight_index;
						addr_q     <= idx_x[AW-1:0];
						in_range_q <= (32'(item.weight_index) < 32'(WEIGHT_COUNT));
						operand_q  <= item.operand_value;
						state_q    <= S_RD;
					end
				end
				S_RD: begin
					entry_q <= rd_data;
					state_q <= is_update ? S_CALC : S_FIN;
				end
				S_CALC: begin
					if (alu_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_idx_q    <= idx_q;
						out_weight_q <= fin_weight;
						out_step_q   <= fin_step;
						out_kind_q   <= fin_kind;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_index = out_idx_q;
	assign result.weight_value = out_weight_q;
	assign result.step_value   = out_step_q;
	assign result.update_kind  = out_kind_q;

	// pipeline completes only while the sequencer waits for it
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_CALC)
		else $error("update pipeline finished outside the wait state");

	// write-back only when finishing an in-range load or update
	a_write_fin: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_FIN && in_range_q && (op_q == OP_LOAD || op_q == OP_UPDATE))
		else $error("memory written outside write-back");

	// an accepted request always reads memory next
	a_accept_rd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RD)
		else $error("accepted request did not go to memory read");

	// stored sign code is always a legal sign
	a_sign_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> wr_data.sign != SIGN_BAD)
		else $error("illegal gradient sign written");

	// a result is only loaded when the output slot is free
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_valid_q && !result.ready |=> state_q == S_FIN)
		else $error("result overwrote a waiting result");

endmodule
